### rtl/pcsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsp_pkg
// Types, codes and constants shared by the PNG chunk stream parser modules.
// ----------------------------------------------------------------------------
package pcsp_pkg;

  // Result kinds.
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD = 3'd1;
  localparam logic [2:0] KIND_PALETTE = 3'd2;
  localparam logic [2:0] KIND_END     = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // Error status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INVALID     = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  // Parser phases.
  localparam logic [3:0] PH_SIG   = 4'd0;
  localparam logic [3:0] PH_HLEN  = 4'd1;
  localparam logic [3:0] PH_HDR   = 4'd2;
  localparam logic [3:0] PH_CLEN  = 4'd3;
  localparam logic [3:0] PH_CNAME = 4'd4;
  localparam logic [3:0] PH_DATA  = 4'd5;
  localparam logic [3:0] PH_CRC   = 4'd6;
  localparam logic [3:0] PH_DONE  = 4'd7;
  localparam logic [3:0] PH_ERR   = 4'd8;

  // Chunk classes.
  localparam logic [1:0] CL_OTHER = 2'd0;
  localparam logic [1:0] CL_IDAT  = 2'd1;
  localparam logic [1:0] CL_PLTE  = 2'd2;
  localparam logic [1:0] CL_IEND  = 2'd3;

  localparam logic [31:0] NAME_IEND = 32'h49454E44;
  localparam logic [31:0] NAME_IDAT = 32'h49444154;
  localparam logic [31:0] NAME_PLTE = 32'h504C5445;

  localparam logic [31:0] HDR_LEN      = 32'd13;
  localparam logic [7:0]  BIT_DEPTH    = 8'd8;
  localparam logic [31:0] CRC_BYTES    = 32'd4;
  localparam logic [31:0] TRIPLET_SIZE = 32'd3;

  // Header chunk byte positions, counted from the first name byte.
  localparam logic [31:0] HP_WIDTH   = 32'd4;
  localparam logic [31:0] HP_HEIGHT  = 32'd8;
  localparam logic [31:0] HP_DEPTH   = 32'd12;
  localparam logic [31:0] HP_COLOR   = 32'd13;
  localparam logic [31:0] HP_METHODS = 32'd14;
  localparam logic [31:0] HP_INTLACE = 32'd16;
  localparam logic [31:0] HP_LAST    = 32'd20;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
  } item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [1:0]  status;
    logic [7:0]  payload_byte;
    logic [7:0]  palette_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [1:0]  color_type;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0: val = 8'h89;
      3'd1: val = 8'h50;
      3'd2: val = 8'h4E;
      3'd3: val = 8'h47;
      3'd4: val = 8'h0D;
      3'd5: val = 8'h0A;
      3'd6: val = 8'h1A;
      default: val = 8'h0A;
    endcase
    return val;
  endfunction

endpackage

### rtl/pcsp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsp_in_stage
// Input register: holds one accepted byte until the parser core takes it.
// ----------------------------------------------------------------------------
module pcsp_in_stage
  import pcsp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### rtl/pcsp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsp_core
// Parser state and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module pcsp_core
  import pcsp_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
)
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    take,
  input  item_t   item,
  output logic    emit,
  output result_t res
);

  localparam int CntW = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [CntW-1:0] PalMax = CntW'(PALETTE_ENTRIES);

  logic [3:0]      phase_r,   phase_nxt;
  logic [31:0]     left_r,    left_nxt;
  logic [31:0]     asm_r,     asm_nxt;
  logic [31:0]     clen_r,    clen_nxt;
  logic [1:0]      class_r,   class_nxt;
  logic [31:0]     hw_r,      hw_nxt;
  logic [31:0]     hh_r,      hh_nxt;
  logic [1:0]      hc_r,      hc_nxt;
  logic [15:0]     hold_r,    hold_nxt;
  logic [1:0]      tpos_r,    tpos_nxt;
  logic [CntW-1:0] pcnt_r,    pcnt_nxt;

  logic [3:0]      ph;
  logic [31:0]     left;
  logic [31:0]     asm_w;
  logic [1:0]      tpos;
  logic [CntW-1:0] pcnt;
  logic [31:0]     shifted;
  logic [7:0]      b;

  always_comb begin
    b = item.byte_value;

    // A start byte restarts the parse and is taken as the first signature byte.
    ph    = phase_r;
    left  = left_r;
    asm_w = asm_r;
    tpos  = tpos_r;
    pcnt  = pcnt_r;
    if (item.start_of_file) begin
      ph    = PH_SIG;
      left  = '0;
      asm_w = '0;
      tpos  = '0;
      pcnt  = '0;
    end
    shifted = {asm_w[23:0], b};

    phase_nxt = ph;
    left_nxt  = left;
    asm_nxt   = asm_w;
    clen_nxt  = clen_r;
    class_nxt = class_r;
    hw_nxt    = hw_r;
    hh_nxt    = hh_r;
    hc_nxt    = hc_r;
    hold_nxt  = hold_r;
    tpos_nxt  = tpos;
    pcnt_nxt  = pcnt;
    emit      = 1'b0;
    res       = '0;

    unique case (ph)
      PH_SIG: begin
        if (b != magic_byte(left[2:0])) begin
          phase_nxt      = PH_ERR;
          emit           = 1'b1;
          res.result_kind = KIND_ERROR;
          res.status     = ST_INVALID;
        end else if (left[2:0] == 3'd7) begin
          phase_nxt = PH_HLEN;
          left_nxt  = '0;
          asm_nxt   = '0;
        end else begin
          left_nxt = left + 32'd1;
        end
      end
      PH_HLEN: begin
        asm_nxt  = shifted;
        left_nxt = left + 32'd1;
        if (left == 32'd3) begin
          if (shifted != HDR_LEN) begin
            phase_nxt       = PH_ERR;
            emit            = 1'b1;
            res.result_kind = KIND_ERROR;
            res.status      = ST_INVALID;
          end else begin
            phase_nxt = PH_HDR;
            left_nxt  = '0;
          end
        end
      end
      PH_HDR: begin
        left_nxt = left + 32'd1;
        if (left >= HP_WIDTH && left < HP_HEIGHT) begin
          hw_nxt = {hw_r[23:0], b};
        end else if (left >= HP_HEIGHT && left < HP_DEPTH) begin
          hh_nxt = {hh_r[23:0], b};
        end else if (left == HP_DEPTH) begin
          if (b != BIT_DEPTH) begin
            phase_nxt       = PH_ERR;
            emit            = 1'b1;
            res.result_kind = KIND_ERROR;
            res.status      = ST_UNSUPPORTED;
          end
        end else if (left == HP_COLOR) begin
          if (b != 8'd0 && b != 8'd2 && b != 8'd3) begin
            phase_nxt       = PH_ERR;
            emit            = 1'b1;
            res.result_kind = KIND_ERROR;
            res.status      = ST_UNSUPPORTED;
          end
          hc_nxt = b[1:0];
        end else if (left >= HP_METHODS && left <= HP_INTLACE) begin
          if (b != 8'd0) begin
            phase_nxt       = PH_ERR;
            emit            = 1'b1;
            res.result_kind = KIND_ERROR;
            res.status      = ST_UNSUPPORTED;
          end
        end else if (left >= HP_LAST) begin
          emit             = 1'b1;
          res.result_kind  = KIND_HEADER;
          res.image_width  = hw_r;
          res.image_height = hh_r;
          res.color_type   = hc_r;
          phase_nxt        = PH_CLEN;
          left_nxt         = '0;
          asm_nxt          = '0;
        end
      end
      PH_CLEN: begin
        asm_nxt  = shifted;
        left_nxt = left + 32'd1;
        if (left == 32'd3) begin
          clen_nxt  = shifted;
          phase_nxt = PH_CNAME;
          left_nxt  = '0;
          asm_nxt   = '0;
        end
      end
      PH_CNAME: begin
        asm_nxt  = shifted;
        left_nxt = left + 32'd1;
        if (left == 32'd3) begin
          asm_nxt = '0;
          if (shifted == NAME_IEND) begin
            class_nxt = CL_IEND;
            phase_nxt = PH_CRC;
            left_nxt  = CRC_BYTES;
          end else begin
            if (shifted == NAME_IDAT) begin
              class_nxt = CL_IDAT;
            end else if (shifted == NAME_PLTE) begin
              class_nxt = CL_PLTE;
              pcnt_nxt  = '0;
              tpos_nxt  = '0;
              hold_nxt  = '0;
            end else begin
              class_nxt = CL_OTHER;
            end
            if (clen_r == 32'd0) begin
              phase_nxt = PH_CRC;
              left_nxt  = CRC_BYTES;
            end else begin
              phase_nxt = PH_DATA;
              left_nxt  = clen_r;
            end
          end
        end
      end
      PH_DATA: begin
        left_nxt = left - 32'd1;
        if (class_r == CL_IDAT) begin
          emit             = 1'b1;
          res.result_kind  = KIND_PAYLOAD;
          res.payload_byte = b;
        // A triplet only starts while at least three bytes remain, so the
        // bytes after the last full triplet fall through here unused.
        end else if (class_r == CL_PLTE && !(tpos == 2'd0 && left < TRIPLET_SIZE)) begin
          unique case (tpos)
            2'd0: begin
              hold_nxt = {b, 8'd0};
              tpos_nxt = 2'd1;
            end
            2'd1: begin
              hold_nxt = {hold_r[15:8], b};
              tpos_nxt = 2'd2;
            end
            default: begin
              if (pcnt < PalMax) begin
                emit              = 1'b1;
                res.result_kind   = KIND_PALETTE;
                res.palette_index = 8'(pcnt);
                res.red           = hold_r[15:8];
                res.green         = hold_r[7:0];
                res.blue          = b;
                pcnt_nxt          = pcnt + 1'b1;
              end
              tpos_nxt = 2'd0;
            end
          endcase
        end
        if (left == 32'd1) begin
          phase_nxt = PH_CRC;
          left_nxt  = CRC_BYTES;
        end
      end
      PH_CRC: begin
        left_nxt = left - 32'd1;
        if (left == 32'd1) begin
          if (class_r == CL_IEND) begin
            emit            = 1'b1;
            res.result_kind = KIND_END;
            phase_nxt       = PH_DONE;
          end else begin
            phase_nxt = PH_CLEN;
            asm_nxt   = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG;
      left_r  <= '0;
      asm_r   <= '0;
      clen_r  <= '0;
      class_r <= CL_OTHER;
      tpos_r  <= '0;
      pcnt_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      asm_r   <= asm_nxt;
      clen_r  <= clen_nxt;
      class_r <= class_nxt;
      tpos_r  <= tpos_nxt;
      pcnt_r  <= pcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hw_r   <= hw_nxt;
      hh_r   <= hh_nxt;
      hc_r   <= hc_nxt;
      hold_r <= hold_nxt;
    end
  end

endmodule

### rtl/pcsp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsp_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module pcsp_out_stage
  import pcsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res_out
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

### rtl/png_chunk_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_chunk_stream_parser
// Parses a PNG byte stream: signature and header checks, IDAT bytes, PLTE
// entries and end of image.
//
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_ready   byte_value, start_of_file
// out_     output     out_valid / out_ready result_kind, status, payload_byte,
//                                           palette_index, red, green, blue,
//                                           image_width, image_height, color_type
//
// One byte is accepted per clock while the output is not stalled; results are registered.
// The input register and the result register each hold one request, so a
// stalled output backs up through them to in_ready without losing a byte.
// Reset is synchronous and active low; it returns the parser to the signature.
// ----------------------------------------------------------------------------
module png_chunk_stream_parser
  import pcsp_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_start_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_result_kind,
  output logic [1:0]  out_status,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_palette_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [31:0] out_image_width,
  output logic [31:0] out_image_height,
  output logic [1:0]  out_color_type
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  logic    free;
  logic    emit;
  result_t res;
  result_t res_q;

  assign in_item.byte_value    = in_byte_value;
  assign in_item.start_of_file = in_start_of_file;
  assign take = item_valid && free;

  pcsp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .take      (take),
    .item_valid(item_valid),
    .item      (item)
  );

  pcsp_core #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .take (take),
    .item (item),
    .emit (emit),
    .res  (res)
  );

  pcsp_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take && emit),
    .res_in   (res),
    .free     (free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res_out  (res_q)
  );

  assign out_result_kind   = res_q.result_kind;
  assign out_status        = res_q.status;
  assign out_payload_byte  = res_q.payload_byte;
  assign out_palette_index = res_q.palette_index;
  assign out_red           = res_q.red;
  assign out_green         = res_q.green;
  assign out_blue          = res_q.blue;
  assign out_image_width   = res_q.image_width;
  assign out_image_height  = res_q.image_height;
  assign out_color_type    = res_q.color_type;

endmodule
